// ===== src/mps_pkg.sv =====
package mps_pkg;

    localparam int COUNT_WIDTH = 16;
    localparam int TICK_WIDTH  = 16;
    localparam int ADDR_WIDTH  = 5;

    localparam logic [31:0] COUNT_MAX32 = (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF
                                        : ((32'd1 << COUNT_WIDTH) - 32'd1);

    // actions
    localparam logic [2:0] ACT_TICK      = 3'd0;
    localparam logic [2:0] ACT_POWER_ON  = 3'd1;
    localparam logic [2:0] ACT_POWER_OFF = 3'd2;
    localparam logic [2:0] ACT_RESET     = 3'd3;
    localparam logic [2:0] ACT_CRASH     = 3'd4;
    localparam logic [2:0] ACT_PIN_EVENT = 3'd5;

    // reported modem states
    localparam logic [2:0] ST_OFFLINE     = 3'd0;
    localparam logic [2:0] ST_BOOTING     = 3'd1;
    localparam logic [2:0] ST_ONLINE      = 3'd2;
    localparam logic [2:0] ST_CRASH_RESET = 3'd3;
    localparam logic [2:0] ST_CRASH_EXIT  = 3'd4;

    // sequence phases
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HOLD   = 3'd1;
    localparam logic [2:0] PH_WAIT   = 3'd2;
    localparam logic [2:0] PH_PULSE  = 3'd3;
    localparam logic [2:0] PH_SETTLE = 3'd4;
    localparam logic [2:0] PH_REQ    = 3'd5;

    // pin vector bit positions
    localparam int PIN_REQ  = 0;
    localparam int PIN_ON   = 1;
    localparam int PIN_RST  = 2;
    localparam int PIN_HOST = 3;
    localparam int PIN_DUMP = 4;

    // register indexes
    localparam logic [2:0] REG_RESET_HOLD   = 3'd0;
    localparam logic [2:0] REG_BOOT_WAIT    = 3'd1;
    localparam logic [2:0] REG_ON_PULSE     = 3'd2;
    localparam logic [2:0] REG_SETTLE       = 3'd3;
    localparam logic [2:0] REG_RESET_REQ    = 3'd4;
    localparam logic [2:0] REG_HAVE_CONTROL = 3'd5;
    localparam logic [2:0] REG_HAVE_DUMP    = 3'd6;
    localparam logic [2:0] REG_HAVE_STATUS  = 3'd7;

    typedef struct packed {
        logic [2:0] action;
        logic       modem_active_level;
        logic       modem_dump_level;
    } in_t;

    typedef struct packed {
        logic       reset_req_pin;
        logic       power_on_pin;
        logic       modem_reset_pin;
        logic       host_active_pin;
        logic       dump_out_pin;
        logic [2:0] modem_state;
        logic       state_report_valid;
        logic       busy_res;
        logic       rejected;
    } out_t;

    typedef struct packed {
        logic [TICK_WIDTH-1:0] reset_hold_ticks;
        logic [TICK_WIDTH-1:0] boot_wait_ticks;
        logic [TICK_WIDTH-1:0] on_pulse_ticks;
        logic [TICK_WIDTH-1:0] settle_ticks;
        logic [TICK_WIDTH-1:0] reset_req_ticks;
        logic                  have_control_lines;
        logic                  have_dump_out_line;
        logic                  have_status_lines;
    } cfg_t;

    // clamp a tick register into the countdown width
    function automatic logic [COUNT_WIDTH-1:0] load_count(input logic [TICK_WIDTH-1:0] ticks);
        logic [31:0] t;
        t = {{(32-TICK_WIDTH){1'b0}}, ticks};
        if (t > COUNT_MAX32)
            t = COUNT_MAX32;
        return t[COUNT_WIDTH-1:0];
    endfunction

endpackage

// ===== src/mps_cfg_regs.sv =====
module mps_cfg_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mps_pkg::ADDR_WIDTH-1:0]   paddr,
    input  logic [31:0]                      pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready,
    output mps_pkg::cfg_t                    cfg
);

    mps_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.reset_hold_ticks   <= 16'd10000;
            cfg_reg.boot_wait_ticks    <= 16'd5000;
            cfg_reg.on_pulse_ticks     <= 16'd6;
            cfg_reg.settle_ticks       <= 16'd2000;
            cfg_reg.reset_req_ticks    <= 16'd1000;
            cfg_reg.have_control_lines <= 1'b1;
            cfg_reg.have_dump_out_line <= 1'b1;
            cfg_reg.have_status_lines  <= 1'b1;
        end
        else if (wr_en)
        begin
            unique case (idx)
                mps_pkg::REG_RESET_HOLD:   cfg_reg.reset_hold_ticks   <= pwdata[15:0];
                mps_pkg::REG_BOOT_WAIT:    cfg_reg.boot_wait_ticks    <= pwdata[15:0];
                mps_pkg::REG_ON_PULSE:     cfg_reg.on_pulse_ticks     <= pwdata[15:0];
                mps_pkg::REG_SETTLE:       cfg_reg.settle_ticks       <= pwdata[15:0];
                mps_pkg::REG_RESET_REQ:    cfg_reg.reset_req_ticks    <= pwdata[15:0];
                mps_pkg::REG_HAVE_CONTROL: cfg_reg.have_control_lines <= pwdata[0];
                mps_pkg::REG_HAVE_DUMP:    cfg_reg.have_dump_out_line <= pwdata[0];
                mps_pkg::REG_HAVE_STATUS:  cfg_reg.have_status_lines  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        prdata = 32'd0;
        unique case (idx)
            mps_pkg::REG_RESET_HOLD:   prdata = {16'd0, cfg_reg.reset_hold_ticks};
            mps_pkg::REG_BOOT_WAIT:    prdata = {16'd0, cfg_reg.boot_wait_ticks};
            mps_pkg::REG_ON_PULSE:     prdata = {16'd0, cfg_reg.on_pulse_ticks};
            mps_pkg::REG_SETTLE:       prdata = {16'd0, cfg_reg.settle_ticks};
            mps_pkg::REG_RESET_REQ:    prdata = {16'd0, cfg_reg.reset_req_ticks};
            mps_pkg::REG_HAVE_CONTROL: prdata = {31'd0, cfg_reg.have_control_lines};
            mps_pkg::REG_HAVE_DUMP:    prdata = {31'd0, cfg_reg.have_dump_out_line};
            mps_pkg::REG_HAVE_STATUS:  prdata = {31'd0, cfg_reg.have_status_lines};
            default:                   prdata = 32'd0;
        endcase
    end

endmodule

// ===== src/mps_core.sv =====
module mps_core (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           fire,
    input  mps_pkg::in_t   item,
    input  mps_pkg::cfg_t  cfg,
    output mps_pkg::out_t  result
);

    logic [2:0]                      cur_reg, cur_next;
    logic [2:0]                      phase_reg, phase_next;
    logic [mps_pkg::COUNT_WIDTH-1:0] count_reg, count_next;
    logic [4:0]                      pins_reg, pins_next;

    logic       busy;
    logic       finish;
    logic       rejected;
    logic       report_valid;
    logic       released;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg   <= mps_pkg::ST_OFFLINE;
            phase_reg <= mps_pkg::PH_IDLE;
            count_reg <= '0;
            pins_reg  <= '0;
        end
        else if (fire)
        begin
            cur_reg   <= cur_next;
            phase_reg <= phase_next;
            count_reg <= count_next;
            pins_reg  <= pins_next;
        end
    end

    assign busy     = (phase_reg != mps_pkg::PH_IDLE);
    assign released = pins_reg[mps_pkg::PIN_RST];

    always_comb
    begin
        cur_next     = cur_reg;
        phase_next   = phase_reg;
        count_next   = count_reg;
        pins_next    = pins_reg;
        finish       = 1'b0;
        rejected     = 1'b0;
        report_valid = 1'b0;

        case (item.action)
            mps_pkg::ACT_TICK:
            begin
                if (busy)
                begin
                    if (count_reg > mps_pkg::COUNT_WIDTH'(1))
                        count_next = count_reg - mps_pkg::COUNT_WIDTH'(1);
                    else
                    begin
                        unique case (phase_reg)
                            mps_pkg::PH_HOLD:
                            begin
                                pins_next[mps_pkg::PIN_RST] = 1'b1;
                                phase_next = mps_pkg::PH_WAIT;
                                count_next = mps_pkg::load_count(cfg.boot_wait_ticks);
                            end
                            mps_pkg::PH_WAIT:
                            begin
                                pins_next[mps_pkg::PIN_REQ] = 1'b1;
                                pins_next[mps_pkg::PIN_ON]  = 1'b1;
                                phase_next = mps_pkg::PH_PULSE;
                                count_next = mps_pkg::load_count(cfg.on_pulse_ticks);
                            end
                            mps_pkg::PH_PULSE:
                            begin
                                pins_next[mps_pkg::PIN_ON] = 1'b0;
                                phase_next = mps_pkg::PH_SETTLE;
                                count_next = mps_pkg::load_count(cfg.settle_ticks);
                            end
                            mps_pkg::PH_SETTLE:
                                finish = 1'b1;
                            mps_pkg::PH_REQ:
                            begin
                                pins_next[mps_pkg::PIN_REQ] = 1'b1;
                                finish = 1'b1;
                            end
                            default:
                            begin
                                phase_next = mps_pkg::PH_IDLE;
                                count_next = '0;
                            end
                        endcase
                    end
                end
            end
            mps_pkg::ACT_POWER_ON:
            begin
                if (busy || !cfg.have_control_lines)
                    rejected = 1'b1;
                else
                begin
                    pins_next[mps_pkg::PIN_REQ] = 1'b0;
                    pins_next[mps_pkg::PIN_ON]  = 1'b0;
                    pins_next[mps_pkg::PIN_RST] = 1'b0;
                    phase_next = mps_pkg::PH_HOLD;
                    count_next = mps_pkg::load_count(cfg.reset_hold_ticks);
                end
            end
            mps_pkg::ACT_POWER_OFF:
            begin
                if (busy || !cfg.have_control_lines)
                    rejected = 1'b1;
                else
                begin
                    pins_next[mps_pkg::PIN_REQ]  = 1'b0;
                    pins_next[mps_pkg::PIN_ON]   = 1'b0;
                    pins_next[mps_pkg::PIN_RST]  = 1'b0;
                    pins_next[mps_pkg::PIN_HOST] = 1'b0;
                    cur_next = mps_pkg::ST_OFFLINE;
                end
            end
            mps_pkg::ACT_RESET:
            begin
                if (busy || !cfg.have_control_lines)
                    rejected = 1'b1;
                else
                begin
                    pins_next[mps_pkg::PIN_REQ] = 1'b0;
                    cur_next   = mps_pkg::ST_OFFLINE;
                    phase_next = mps_pkg::PH_REQ;
                    count_next = mps_pkg::load_count(cfg.reset_req_ticks);
                end
            end
            mps_pkg::ACT_CRASH:
            begin
                if (busy || !cfg.have_dump_out_line)
                    rejected = 1'b1;
                else
                    pins_next[mps_pkg::PIN_DUMP] = 1'b1;
            end
            mps_pkg::ACT_PIN_EVENT:
            begin
                if (cfg.have_control_lines && cfg.have_status_lines)
                begin
                    report_valid = 1'b1;
                    if (released && item.modem_active_level)
                        cur_next = mps_pkg::ST_ONLINE;
                    else if (released)
                    begin
                        if (cur_reg == mps_pkg::ST_ONLINE)
                            cur_next = item.modem_dump_level ? mps_pkg::ST_CRASH_EXIT
                                                             : mps_pkg::ST_CRASH_RESET;
                        else
                            cur_next = mps_pkg::ST_BOOTING;
                    end
                    else
                        cur_next = mps_pkg::ST_OFFLINE;
                end
            end
            default: ;
        endcase

        // end of power-on or reset-request sequence
        if (finish)
        begin
            pins_next[mps_pkg::PIN_HOST] = 1'b1;
            if (cfg.have_dump_out_line)
                pins_next[mps_pkg::PIN_DUMP] = 1'b0;
            cur_next   = mps_pkg::ST_BOOTING;
            phase_next = mps_pkg::PH_IDLE;
            count_next = '0;
        end
    end

    always_comb
    begin
        result.reset_req_pin      = pins_next[mps_pkg::PIN_REQ];
        result.power_on_pin       = pins_next[mps_pkg::PIN_ON];
        result.modem_reset_pin    = pins_next[mps_pkg::PIN_RST];
        result.host_active_pin    = pins_next[mps_pkg::PIN_HOST];
        result.dump_out_pin       = pins_next[mps_pkg::PIN_DUMP];
        result.modem_state        = cur_next;
        result.state_report_valid = report_valid;
        result.busy_res           = (phase_next != mps_pkg::PH_IDLE);
        result.rejected           = rejected;
    end

endmodule

// ===== src/modem_power_sequencer_unit.sv =====
// An accepted item is held in the input register and then in the result register.
// Throughput: one item per cycle while results are taken; a result held by the receiver
// stalls the input once the input register is also full.
// Each item's sequencer update is a single pass of logic from the input register.
// Reset (rst_n, async low): modem offline, no sequence running, all pins low,
// tick registers and line-present flags at their defaults, both stages empty.
module modem_power_sequencer_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  mps_pkg::in_t                   in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output mps_pkg::out_t                  out_data,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mps_pkg::ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    mps_pkg::cfg_t cfg;
    mps_pkg::in_t  in_reg;
    mps_pkg::out_t out_reg;
    mps_pkg::out_t result;
    logic          in_valid_reg;
    logic          out_valid_reg;
    logic          advance;

    mps_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    mps_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (in_reg),
        .cfg    (cfg),
        .result (result)
    );

    // item moves into the result register when that slot is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_reg <= in_data;
        if (advance)
            out_reg <= result;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule
